FILE: rtl/assert_macros.svh
// assertion macros for the biquad rtl, used by bqf_ctrl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BQF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BQF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bqf_pkg.sv
// types and constants for the biquad filter
// no dependencies
package bqf_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 32;
  localparam int FRAC_BITS        = 28;
  localparam int STATE_W          = 60;
  localparam int WIDE_W           = 66;
  localparam int NUM_COEFS        = 5;
  localparam int CFG_IDX_W        = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_B0,
    ST_Y,
    ST_A1,
    ST_B2,
    ST_A2,
    ST_UPD
  } state_t;

  typedef enum logic [2:0] {
    MUL_B0,
    MUL_B1,
    MUL_B2,
    MUL_A1,
    MUL_A2
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     cap_y;
    logic     n1_init;
    logic     n1_sub;
    logic     n2_init;
    logic     upd;
    logic     out_load;
  } bqf_cmd_t;

endpackage

FILE: rtl/bqf_cfg_regs.sv
// coefficient register bank
// depends on bqf_pkg
module bqf_cfg_regs #(
  parameter int COEF_WIDTH = bqf_pkg::COEF_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [COEF_WIDTH-1:0]                 cfg_wdata,
  output logic signed [COEF_WIDTH-1:0]          coef [bqf_pkg::NUM_COEFS]
);
  import bqf_pkg::*;

  localparam logic [COEF_WIDTH-1:0] B0_RESET = COEF_WIDTH'(64'd1 << FRAC_BITS);

  logic [COEF_WIDTH-1:0] coef_r [NUM_COEFS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[COEF_B0] <= B0_RESET;
      coef_r[COEF_B1] <= '0;
      coef_r[COEF_B2] <= '0;
      coef_r[COEF_A1] <= '0;
      coef_r[COEF_A2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        COEF_B0: coef_r[COEF_B0] <= cfg_wdata;
        COEF_B1: coef_r[COEF_B1] <= cfg_wdata;
        COEF_B2: coef_r[COEF_B2] <= cfg_wdata;
        COEF_A1: coef_r[COEF_A1] <= cfg_wdata;
        COEF_A2: coef_r[COEF_A2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_COEFS; i++) begin
      coef[i] = $signed(coef_r[i]);
    end
  end

endmodule

FILE: rtl/bqf_datapath.sv
// shared multiplier, accumulators, delay states and output register
// depends on bqf_pkg
module bqf_datapath #(
  parameter int SAMPLE_WIDTH = bqf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = bqf_pkg::COEF_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bqf_pkg::bqf_cmd_t                 cmd,
  input  logic signed [COEF_WIDTH-1:0]      coef [bqf_pkg::NUM_COEFS],
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  input  logic                              in_clear_first,
  output logic signed [SAMPLE_WIDTH-1:0]    out_sample,
  output logic                              out_clipped
);
  import bqf_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam logic signed [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [WIDE_W-1:0] Y_MAX =
    (WIDE_W'(1) <<< (SAMPLE_WIDTH - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] Y_MIN = ~Y_MAX;
  localparam logic signed [WIDE_W-1:0] S_MAX =
    (WIDE_W'(1) <<< (STATE_W - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] S_MIN = ~S_MAX;

  logic signed [SAMPLE_WIDTH-1:0] x_r, y_r, out_sample_r;
  logic                           hit_r, out_clipped_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [WIDE_W-1:0]       n1_r, n2_r;
  logic signed [STATE_W-1:0]      d1_r, d2_r;

  logic signed [COEF_WIDTH-1:0]   mul_a;
  logic signed [SAMPLE_WIDTH-1:0] mul_b;
  logic signed [PROD_W-1:0]       prod_nxt;
  logic signed [WIDE_W-1:0]       prod_w, acc, acc_sh, n2_full;
  logic signed [SAMPLE_WIDTH-1:0] y_nxt;
  logic                           y_hit, d1_hit, d2_hit;
  logic signed [STATE_W-1:0]      d1_nxt, d2_nxt;

  always_comb begin
    case (cmd.mul_sel)
      MUL_B0:  mul_a = coef[COEF_B0];
      MUL_B1:  mul_a = coef[COEF_B1];
      MUL_B2:  mul_a = coef[COEF_B2];
      MUL_A1:  mul_a = coef[COEF_A1];
      MUL_A2:  mul_a = coef[COEF_A2];
      default: mul_a = '0;
    endcase
    mul_b    = (cmd.mul_sel == MUL_A1 || cmd.mul_sel == MUL_A2) ? y_r : x_r;
    prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    prod_w = WIDE_W'(prod_r);
    acc    = prod_w + WIDE_W'(d1_r) + ROUND_HALF;
    acc_sh = acc >>> FRAC_BITS;
    y_hit  = 1'b1;
    if (acc_sh > Y_MAX) begin
      y_nxt = SAMPLE_WIDTH'(Y_MAX);
    end else if (acc_sh < Y_MIN) begin
      y_nxt = SAMPLE_WIDTH'(Y_MIN);
    end else begin
      y_nxt = SAMPLE_WIDTH'(acc_sh);
      y_hit = 1'b0;
    end

    n2_full = n2_r - prod_w;

    d1_hit = 1'b1;
    if (n1_r > S_MAX) begin
      d1_nxt = STATE_W'(S_MAX);
    end else if (n1_r < S_MIN) begin
      d1_nxt = STATE_W'(S_MIN);
    end else begin
      d1_nxt = STATE_W'(n1_r);
      d1_hit = 1'b0;
    end

    d2_hit = 1'b1;
    if (n2_full > S_MAX) begin
      d2_nxt = STATE_W'(S_MAX);
    end else if (n2_full < S_MIN) begin
      d2_nxt = STATE_W'(S_MIN);
    end else begin
      d2_nxt = STATE_W'(n2_full);
      d2_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else if (cmd.load_in && in_clear_first) begin
      d1_r <= '0;
      d2_r <= '0;
    end else if (cmd.upd) begin
      d1_r <= d1_nxt;
      d2_r <= d2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r   <= in_sample;
      hit_r <= 1'b0;
    end
    if (cmd.cap_y) begin
      y_r   <= y_nxt;
      hit_r <= y_hit;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.n1_init) begin
      n1_r <= prod_w + WIDE_W'(d2_r);
    end
    if (cmd.n1_sub) begin
      n1_r <= n1_r - prod_w;
    end
    if (cmd.n2_init) begin
      n2_r <= prod_w;
    end
    if (cmd.out_load) begin
      out_sample_r  <= y_r;
      out_clipped_r <= hit_r | d1_hit | d2_hit;
    end
  end

  assign out_sample  = out_sample_r;
  assign out_clipped = out_clipped_r;

endmodule

FILE: rtl/bqf_ctrl.sv
// sequencer for the five multiplies and the output handshake
// depends on bqf_pkg and assert_macros.svh
`include "assert_macros.svh"

module bqf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bqf_pkg::bqf_cmd_t  cmd
);
  import bqf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_B0;
    accept    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        accept = in_valid;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_B0;
        end
      end
      ST_B0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_B0;
        state_nxt   = ST_Y;
      end
      ST_Y: begin
        cmd.cap_y   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_B1;
        state_nxt   = ST_A1;
      end
      ST_A1: begin
        cmd.n1_init = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A1;
        state_nxt   = ST_B2;
      end
      ST_B2: begin
        cmd.n1_sub  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_B2;
        state_nxt   = ST_A2;
      end
      ST_A2: begin
        cmd.n2_init = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A2;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        // state update repeats harmlessly while the output slot is full
        cmd.upd = 1'b1;
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  `BQF_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_r || out_ready,
                  "result register overwritten while full")
  `BQF_ASSERT_NXT(a_accept_starts, clk, rst_n, accept, state_r == ST_B0,
                  "accepted transaction did not start the sequence")
  `BQF_ASSERT_IMP(a_result_from_upd, clk, rst_n, $rose(out_valid_r),
                  $past(state_r) == ST_UPD, "result shown without an update step")

endmodule

FILE: rtl/biquad_iir_filter.sv
// biquad iir section, transposed direct form ii, fixed point
// depends on bqf_pkg, bqf_cfg_regs, bqf_ctrl, bqf_datapath
//
//   port group   handshake              payload
//   in_          in_valid / in_ready    in_sample, in_clear_first
//   out_         out_valid / out_ready  out_sample, out_clipped
//   cfg_         cfg_we                 cfg_index, cfg_wdata
//
// a result is valid once its five products have gone through one shared registered multiplier
// and the update step has run; the next input is taken in the idle state that follows, so a
// new sample is accepted only after the previous one has finished its sequence.
// a full output register holds the sequence in its last step until it drains.
// synchronous active-low reset: b0 = 1.0, other coefficients and both states zero.
module biquad_iir_filter #(
  parameter int SAMPLE_WIDTH = bqf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = bqf_pkg::COEF_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  input  logic                              in_clear_first,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]    out_sample,
  output logic                              out_clipped,
  input  logic                              cfg_we,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [COEF_WIDTH-1:0]             cfg_wdata
);
  import bqf_pkg::*;

  logic signed [COEF_WIDTH-1:0] coef [NUM_COEFS];
  bqf_cmd_t                     cmd;

  bqf_cfg_regs #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  bqf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bqf_datapath #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .coef           (coef),
    .in_sample      (in_sample),
    .in_clear_first (in_clear_first),
    .out_sample     (out_sample),
    .out_clipped    (out_clipped)
  );

endmodule

FILE: tb/sv/biquad_iir_filter_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for biquad_iir_filter: directed and random samples, coefficient sets
// depends on bqf_pkg and the biquad_iir_filter rtl; a tracker class predicts every output
module biquad_iir_filter_tb;
  import bqf_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int CW = COEF_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 172;
  localparam int NUM_PHASES = 8;

  typedef logic signed [SW-1:0] sample_t;
  typedef logic signed [CW-1:0] coef_t;
  typedef logic signed [71:0] wide_t;

  typedef enum {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;
  typedef enum {COEFS_STABLE, COEFS_FULL, COEFS_MAX, COEFS_MIN, COEFS_ZERO} coef_kind_t;

  localparam sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam coef_t C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coef_t C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coef_t C_ONE = coef_t'(1) <<< FRAC_BITS;
  localparam coef_t C_HALF = coef_t'(1) <<< (FRAC_BITS - 1);

  class biquad_tracker;
    typedef struct packed {
      sample_t sample;
      logic    clipped;
    } filter_out_t;

    coef_t coefs [NUM_COEFS];
    logic signed [STATE_W-1:0] delay_one, delay_two;
    filter_out_t pending_outputs [$];
    int mismatch_count;

    function void reset_model();
      coefs[COEF_B0] = C_ONE;
      coefs[COEF_B1] = '0;
      coefs[COEF_B2] = '0;
      coefs[COEF_A1] = '0;
      coefs[COEF_A2] = '0;
      delay_one = '0;
      delay_two = '0;
      pending_outputs.delete();
      mismatch_count = 0;
    endfunction

    function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] value);
      if (idx < NUM_COEFS) coefs[idx] = value;
    endfunction

    function wide_t saturate(wide_t v, int w, inout bit hit);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        hit = 1'b1;
        return hi;
      end
      if (v < lo) begin
        hit = 1'b1;
        return lo;
      end
      return v;
    endfunction

    // one step of the section, expected output queued
    function void filter_sample(sample_t x_in, logic clear_first);
      wide_t x, b0, b1, b2, a1, a2, d1, d2, acc, y, n1, n2;
      bit hit;
      filter_out_t res;
      hit = 1'b0;
      if (clear_first) begin
        delay_one = '0;
        delay_two = '0;
      end
      x = x_in;
      b0 = coefs[COEF_B0];
      b1 = coefs[COEF_B1];
      b2 = coefs[COEF_B2];
      a1 = coefs[COEF_A1];
      a2 = coefs[COEF_A2];
      d1 = delay_one;
      d2 = delay_two;
      acc = b0 * x + d1 + (wide_t'(1) <<< (FRAC_BITS - 1));
      y = saturate(acc >>> FRAC_BITS, SW, hit);
      n1 = b1 * x - a1 * y + d2;
      n2 = b2 * x - a2 * y;
      n1 = saturate(n1, STATE_W, hit);
      n2 = saturate(n2, STATE_W, hit);
      delay_one = n1[STATE_W-1:0];
      delay_two = n2[STATE_W-1:0];
      res.sample = y[SW-1:0];
      res.clipped = hit;
      pending_outputs.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
    endtask

    task check_output(sample_t y, logic clipped);
      filter_out_t want;
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("output %0d with nothing expected", y));
        return;
      end
      want = pending_outputs.pop_front();
      if (y !== want.sample)
        report_mismatch($sformatf("out_sample %0d, expected %0d", y, want.sample));
      if (clipped !== want.clipped)
        report_mismatch($sformatf("out_clipped %b, expected %b (sample %0d)",
                                  clipped, want.clipped, want.sample));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  sample_t in_sample;
  logic in_clear_first;
  logic out_valid;
  logic out_ready = 1'b0;
  sample_t out_sample;
  logic out_clipped;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0] cfg_wdata;

  biquad_tracker tracker;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int cycle_count = 0;

  biquad_iir_filter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_clear_first (in_clear_first),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample     (out_sample),
    .out_clipped    (out_clipped),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("biquad_iir_filter regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_output(out_sample, out_clipped);
  end

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      IDLE_TX: begin
        tx_idle_pct = 87;
        rx_stall_pct = 0;
      end
      IDLE_RX: begin
        tx_idle_pct = 0;
        rx_stall_pct = 87;
      end
      default: begin
        tx_idle_pct = 22;
        rx_stall_pct = 22;
      end
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_sample(sample_t s, logic clear_first);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = s;
    in_clear_first = clear_first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.filter_sample(s, clear_first);
    @(negedge clk);
  endtask

  // wait for all outputs, then let the pipeline go quiet
  task automatic settle();
    in_valid = 1'b0;
    while (tracker.pending_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    tracker.set_coef(idx, value);
    @(negedge clk);
  endtask

  task automatic set_filter(coef_t b0, coef_t b1, coef_t b2, coef_t a1, coef_t a2);
    write_reg(COEF_B0, b0);
    write_reg(COEF_B1, b1);
    write_reg(COEF_B2, b2);
    write_reg(COEF_A1, a1);
    write_reg(COEF_A2, a2);
    // an unmapped index must leave the coefficients alone
    write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, NUM_COEFS)), $urandom());
    cfg_we = 1'b0;
  endtask

  task automatic choose_filter(coef_kind_t kind);
    int a2_lim;
    longint a1_lim;
    int a1, a2;
    a2_lim = (C_ONE / 10) * 9;
    case (kind)
      COEFS_STABLE: begin
        // inside the stability triangle so the states keep moving
        a2 = int'($urandom_range(2 * a2_lim)) - a2_lim;
        a1_lim = ((longint'(C_ONE) + a2) * 95) / 100;
        a1 = int'(longint'($urandom_range(32'(2 * a1_lim))) - a1_lim);
        set_filter(coef_t'(int'($urandom_range(2 * C_ONE)) - C_ONE),
                   coef_t'(int'($urandom_range(2 * C_ONE)) - C_ONE),
                   coef_t'(int'($urandom_range(2 * C_ONE)) - C_ONE),
                   coef_t'(a1), coef_t'(a2));
      end
      COEFS_FULL: set_filter($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      COEFS_MAX: set_filter(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
      COEFS_MIN: set_filter(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
      default: set_filter('0, '0, '0, '0, '0);
    endcase
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(3))
      0: return sample_t'($urandom());
      1: return sample_t'(int'($urandom_range(512)) - 256);
      default: return sample_t'(int'($urandom_range(1 << 21)) - (1 << 20));
    endcase
  endfunction

  initial begin
    coef_kind_t phase_kind [NUM_PHASES];
    phase_kind = '{COEFS_STABLE, COEFS_FULL, COEFS_MAX, COEFS_STABLE,
                   COEFS_MIN, COEFS_ZERO, COEFS_FULL, COEFS_STABLE};
    tracker = new();
    tracker.reset_model();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_clear_first = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // reset coefficients pass the sample through
    send_sample('0, 1'b0);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    send_sample(sample_t'('h555555), 1'b0);
    send_sample(sample_t'('haaaaaa), 1'b0);
    settle();

    // exact halves round toward plus infinity
    set_filter(C_HALF, '0, '0, '0, '0);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(3), 1'b0);
    send_sample(sample_t'(-3), 1'b0);
    settle();

    // full-scale gain clips the output
    set_filter(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b1);
    send_sample('0, 1'b0);
    settle();

    set_filter(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(sample_t'(1), 1'b1);
    settle();

    // delay path and clear of built-up state
    set_filter(C_ONE, C_ONE, C_ONE, C_HALF, C_HALF >>> 1);
    send_sample(sample_t'(1000), 1'b0);
    send_sample('0, 1'b0);
    send_sample('0, 1'b1);
    send_sample('0, 1'b0);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      choose_filter(phase_kind[p]);
      set_idle(idle_mode_t'(p % 4));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(63) == 0) begin
          in_valid = 1'b0;
          while (tracker.pending_outputs.size() != 0) @(posedge clk);
          @(negedge clk);
        end
        send_sample(rand_sample(), ($urandom_range(24) == 0));
      end
      settle();
    end

    if (tracker.mismatch_count == 0) begin
      $display("biquad_iir_filter regression: pass");
    end else begin
      $display("biquad_iir_filter regression: fail");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/bqf_pkg.sv
rtl/bqf_cfg_regs.sv
rtl/bqf_datapath.sv
rtl/bqf_ctrl.sv
rtl/biquad_iir_filter.sv
tb/sv/biquad_iir_filter_tb.sv
